// File: sv/imrot_pkg.sv
// Shared constants, types and helpers for the nearest-neighbor image rotator.
package imrot_pkg;

  localparam int MAX_WIDTH      = 64;
  localparam int MAX_HEIGHT     = 64;
  localparam int PIXEL_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;

  localparam int DIM_BITS      = 7;
  localparam int COEF_BITS     = 16;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS     = $clog2(STORE_DEPTH);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COS_COEF     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIN_COEF     = 2'd3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

  localparam int OUT_DEPTH    = 8;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [DIM_BITS-1:0]         w;
    logic [DIM_BITS-1:0]         h;
    logic signed [COEF_BITS-1:0] cos_coef;
    logic signed [COEF_BITS-1:0] sin_coef;
  } cfg_t;

  typedef struct packed {
    logic                  is_req;
    logic [PIXEL_BITS-1:0] pix;
    logic [ADDR_BITS-1:0]  addr;
    logic [COL_BITS-1:0]   col;
    logic [ROW_BITS-1:0]   row;
    logic                  last;
  } cmd_t;

  typedef struct packed {
    logic [OUT_CNT_BITS-1:0] reserved;
    logic [OUT_CNT_BITS-1:0] out_cnt;
  } bstat_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] maxv);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/imrot_in_if.sv
// Input item channel: load or request, with source pixel.
interface imrot_in_if import imrot_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, kind, pixel_in, input ready);
  modport sink (input valid, kind, pixel_in, output ready);
endinterface

// File: sv/imrot_out_if.sv
// Result item channel: rotated pixel and end-of-frame flag.
interface imrot_out_if import imrot_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  last;

  modport source (output valid, pixel_out, last, input ready);
  modport sink (input valid, pixel_out, last, output ready);
endinterface

// File: sv/imrot_front.sv
// Front end: accepts items, tracks load and output raster positions, builds commands.
module imrot_front import imrot_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  imrot_in_if.sink   in_ch,
  input  cfg_t       cfg,
  input  logic       size_clr,
  input  logic       q_ready,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [ADDR_BITS-1:0] load_pos_r, load_pos_nxt;
  logic [COL_BITS-1:0]  col_r, col_nxt;
  logic [ROW_BITS-1:0]  row_r, row_nxt;
  logic [ADDR_BITS:0]   total;
  logic [ADDR_BITS:0]   pos_inc;
  logic [DIM_BITS-1:0]  col_inc;
  logic [DIM_BITS-1:0]  row_inc;
  logic                 fire;

  assign in_ch.ready = q_ready;
  assign fire        = in_ch.valid && q_ready;
  assign total       = (ADDR_BITS+1)'(cfg.w) * (ADDR_BITS+1)'(cfg.h);
  assign pos_inc     = (ADDR_BITS+1)'(load_pos_r) + (ADDR_BITS+1)'(1);
  assign col_inc     = DIM_BITS'(col_r) + DIM_BITS'(1);
  assign row_inc     = DIM_BITS'(row_r) + DIM_BITS'(1);

  always_comb begin
    push            = fire;
    push_cmd.is_req = (in_ch.kind == KIND_REQ);
    push_cmd.pix    = in_ch.pixel_in;
    push_cmd.addr   = load_pos_r;
    push_cmd.col    = col_r;
    push_cmd.row    = row_r;
    push_cmd.last   = (DIM_BITS'(col_r) == cfg.w - DIM_BITS'(1)) &&
                      (DIM_BITS'(row_r) == cfg.h - DIM_BITS'(1));
  end

  always_comb begin
    load_pos_nxt = load_pos_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (size_clr) begin
      load_pos_nxt = '0;
      col_nxt      = '0;
      row_nxt      = '0;
    end else if (fire) begin
      if (in_ch.kind == KIND_LOAD) begin
        load_pos_nxt = (pos_inc >= total) ? '0 : pos_inc[ADDR_BITS-1:0];
      end else if (col_inc >= cfg.w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= cfg.h) ? '0 : row_inc[ROW_BITS-1:0];
      end else begin
        col_nxt = col_inc[COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

endmodule

// File: sv/imrot_cmdq.sv
// Command queue between front end and back end.
module imrot_cmdq import imrot_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t                     q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_BITS-1:0] cnt_r, cnt_nxt;

  assign ready = (cnt_r != CMDQ_CNT_BITS'(CMDQ_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + CMDQ_PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + CMDQ_PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CMDQ_CNT_BITS'(push) - CMDQ_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: sv/imrot_back.sv
// Back end: rotation math pipeline, frame store and result queue.
module imrot_back import imrot_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  imrot_out_if.source out_ch,
  output bstat_t      bstat
);

  localparam int D_BITS    = ((COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS) + 2;
  localparam int PROD_BITS = D_BITS + COEF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int Q_BITS    = SUM_BITS - COEF_FRAC_BITS;
  localparam int S_BITS    = Q_BITS + 1;
  localparam int LIN_BITS  = ADDR_BITS + 1;

  typedef struct packed {
    logic                  is_req;
    logic [PIXEL_BITS-1:0] pix;
    logic [ADDR_BITS-1:0]  addr;
    logic                  last;
  } tag_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic                  last;
  } res_t;

  function automatic logic signed [Q_BITS-1:0] trunc_q(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] adj;
    adj = v + (v[SUM_BITS-1] ? SUM_BITS'((1 << COEF_FRAC_BITS) - 1) : SUM_BITS'(0));
    return adj[SUM_BITS-1:COEF_FRAC_BITS];
  endfunction

  logic [DIM_BITS-1:0]         cx, cy;
  logic signed [D_BITS-1:0]    dx, dy;

  // stage 1: products
  logic                        v1_r;
  tag_t                        t1_r, t1_nxt;
  logic signed [PROD_BITS-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [PROD_BITS-1:0] pxc_nxt, pys_nxt, pxs_nxt, pyc_nxt;

  // stage 2: source coordinates
  logic                        v2_r;
  tag_t                        t2_r;
  logic signed [SUM_BITS-1:0]  sum_x, sum_y;
  logic signed [S_BITS-1:0]    sx_s, sy_s;
  logic [COL_BITS-1:0]         sx_r;
  logic [ROW_BITS-1:0]         sy_r;
  logic                        inb_nxt, inb2_r;

  // stage 3: store address
  logic                        v3_r;
  tag_t                        t3_r, t3_nxt;
  logic [LIN_BITS-1:0]         lin;
  logic                        inb3_r;

  // stage 4: store access
  logic [PIXEL_BITS-1:0]       mem [STORE_DEPTH];
  logic [PIXEL_BITS-1:0]       rd_r;
  logic                        v4_r, inb4_r, last4_r;

  // result queue
  res_t                        fifo_r [OUT_DEPTH];
  res_t                        push_res;
  logic [OUT_PTR_BITS-1:0]     wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_BITS-1:0]     out_cnt_r, out_cnt_nxt;
  logic [OUT_CNT_BITS-1:0]     reserved_r, reserved_nxt;
  logic                        out_fire;
  logic                        pop_req;

  assign cmd_pop  = cmd_valid && (!cmd.is_req || reserved_r < OUT_CNT_BITS'(OUT_DEPTH));
  assign pop_req  = cmd_pop && cmd.is_req;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign cx = cfg.w >> 1;
  assign cy = cfg.h >> 1;

  always_comb begin
    dx      = $signed(D_BITS'(cmd.col)) - $signed(D_BITS'(cx));
    dy      = $signed(D_BITS'(cmd.row)) - $signed(D_BITS'(cy));
    pxc_nxt = PROD_BITS'(dx * cfg.cos_coef);
    pys_nxt = PROD_BITS'(dy * cfg.sin_coef);
    pxs_nxt = PROD_BITS'(dx * cfg.sin_coef);
    pyc_nxt = PROD_BITS'(dy * cfg.cos_coef);
    t1_nxt.is_req = cmd.is_req;
    t1_nxt.pix    = cmd.pix;
    t1_nxt.addr   = cmd.addr;
    t1_nxt.last   = cmd.last;
  end

  always_comb begin
    sum_x   = SUM_BITS'(pxc_r) - SUM_BITS'(pys_r);
    sum_y   = SUM_BITS'(pxs_r) + SUM_BITS'(pyc_r);
    sx_s    = S_BITS'(trunc_q(sum_x)) + $signed(S_BITS'(cx));
    sy_s    = S_BITS'(trunc_q(sum_y)) + $signed(S_BITS'(cy));
    inb_nxt = !sx_s[S_BITS-1] && ($unsigned(sx_s) < S_BITS'(cfg.w)) &&
              !sy_s[S_BITS-1] && ($unsigned(sy_s) < S_BITS'(cfg.h));
  end

  always_comb begin
    lin         = LIN_BITS'(sy_r) * LIN_BITS'(cfg.w) + LIN_BITS'(sx_r);
    t3_nxt      = t2_r;
    t3_nxt.addr = t2_r.is_req ? lin[ADDR_BITS-1:0] : t2_r.addr;
  end

  always_comb begin
    push_res.pix  = inb4_r ? rd_r : '0;
    push_res.last = last4_r;
    out_cnt_nxt   = out_cnt_r + OUT_CNT_BITS'(v4_r) - OUT_CNT_BITS'(out_fire);
    reserved_nxt  = reserved_r + OUT_CNT_BITS'(pop_req) - OUT_CNT_BITS'(out_fire);
  end

  assign out_ch.valid     = (out_cnt_r != '0);
  assign out_ch.pixel_out = fifo_r[rd_ptr_r].pix;
  assign out_ch.last      = fifo_r[rd_ptr_r].last;

  assign bstat.reserved = reserved_r;
  assign bstat.out_cnt  = out_cnt_r;

  always_ff @(posedge clk) begin
    t1_r  <= t1_nxt;
    pxc_r <= pxc_nxt;
    pys_r <= pys_nxt;
    pxs_r <= pxs_nxt;
    pyc_r <= pyc_nxt;
    t2_r   <= t1_r;
    sx_r   <= sx_s[COL_BITS-1:0];
    sy_r   <= sy_s[ROW_BITS-1:0];
    inb2_r <= inb_nxt;
    t3_r   <= t3_nxt;
    inb3_r <= inb2_r;
    inb4_r  <= inb3_r;
    last4_r <= t3_r.last;
  end

  always_ff @(posedge clk) begin
    if (v3_r && !t3_r.is_req) begin
      mem[t3_r.addr] <= t3_r.pix;
    end
    rd_r <= mem[t3_r.addr];
  end

  always_ff @(posedge clk) begin
    if (v4_r) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      out_cnt_r  <= '0;
      reserved_r <= '0;
    end else begin
      v1_r       <= cmd_pop;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      v4_r       <= v3_r && t3_r.is_req;
      wr_ptr_r   <= v4_r ? wr_ptr_r + OUT_PTR_BITS'(1) : wr_ptr_r;
      rd_ptr_r   <= out_fire ? rd_ptr_r + OUT_PTR_BITS'(1) : rd_ptr_r;
      out_cnt_r  <= out_cnt_nxt;
      reserved_r <= reserved_nxt;
    end
  end

endmodule

// File: sv/image_rotate_nearest_core.sv
// Top level of the nearest-neighbor image rotator: config registers and block wiring.
//
//   port      dir   handshake      payload
//   in_ch     in    valid/ready    kind, pixel_in
//   out_ch    out   valid/ready    pixel_out, last
//   cfg_*     in    cfg_we         cfg_index, cfg_data
//
// Sustained rate is one item per cycle while result slots are free; a request
// passes the queue, products, coordinates, address, frame store read and result
// queue to out_ch. Loads give no result and write the store in the same slot.
// Synchronous active-low reset; the frame store is not cleared.
// A stalled out_ch backs up into an 8-entry result queue and then the command
// queue; a load at the queue head still issues while result slots are all reserved.
module image_rotate_nearest_core import imrot_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  imrot_in_if.sink                 in_ch,
  imrot_out_if.source              out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [DIM_BITS-1:0]         width_r, height_r;
  logic signed [COEF_BITS-1:0] cos_r, sin_r;
  cfg_t                        cfg;
  logic                        size_clr;
  logic                        push, q_ready;
  cmd_t                        push_cmd;
  logic                        cmd_valid, cmd_pop;
  cmd_t                        cmd_head;
  bstat_t                      bstat;

  assign cfg.w        = clamp_dim(width_r, DIM_BITS'(MAX_WIDTH));
  assign cfg.h        = clamp_dim(height_r, DIM_BITS'(MAX_HEIGHT));
  assign cfg.cos_coef = cos_r;
  assign cfg.sin_coef = sin_r;
  assign size_clr     = cfg_we && (cfg_index == CFG_FRAME_WIDTH ||
                                   cfg_index == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_BITS'(MAX_WIDTH);
      height_r <= DIM_BITS'(MAX_HEIGHT);
      cos_r    <= COEF_BITS'(1 << COEF_FRAC_BITS);
      sin_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= cfg_data[DIM_BITS-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_data[DIM_BITS-1:0];
        CFG_COS_COEF:     cos_r    <= $signed(cfg_data[COEF_BITS-1:0]);
        CFG_SIN_COEF:     sin_r    <= $signed(cfg_data[COEF_BITS-1:0]);
        default: ;
      endcase
    end
  end

  imrot_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .size_clr (size_clr),
    .q_ready  (q_ready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  imrot_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .valid    (cmd_valid),
    .head     (cmd_head),
    .pop      (cmd_pop)
  );

  imrot_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch),
    .bstat     (bstat)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_reserved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.reserved <= OUT_CNT_BITS'(OUT_DEPTH))
    else $error("result slots over-reserved");

  a_queued_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.out_cnt <= bstat.reserved)
    else $error("queued results exceed reserved slots");

  a_out_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> bstat.reserved != '0)
    else $error("result shown with no reserved slot");

endmodule
